@@ src/can_frame_to_pwm_period_duty_macros.svh @@
// assertion macros used by the checker file
`ifndef CAN_FRAME_TO_PWM_PERIOD_DUTY_MACROS_SVH
`define CAN_FRAME_TO_PWM_PERIOD_DUTY_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfpd check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfpd check failed");

`endif

@@ src/cfpd_pkg.sv @@
// types and constants shared by the frame to pwm settings block
package cfpd_pkg;

   localparam int ID_W     = 29;
   localparam int CLK_W    = 28;
   localparam int BYTE_W   = 8;
   localparam int FREQ_W   = 16;
   localparam int VAL_W    = 16;
   localparam int CHAN_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 29;
   localparam int PROD_W   = BYTE_W + CLK_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_ID = 2'd2;

   localparam logic [CLK_W-1:0] CLOCK_HZ_RESET  = 28'd16000000;
   localparam logic [ID_W-1:0]  FIRST_ID_RESET  = 29'h20;
   localparam logic [ID_W-1:0]  SECOND_ID_RESET = 29'h23;

   // divide by 100 as a multiply: exact for products below 2^23
   localparam int SCALE_IN_W = 23;
   localparam int RECIP_W    = 24;
   localparam int RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
   localparam int SCALED_W   = SCALE_IN_W + RECIP_W;

   // duty*q at or above this gives a compare over 16 bits
   localparam logic [PROD_W-1:0] CMP_PROD_LIMIT = 36'd6553600;
   // quotient above this gives a top over 16 bits
   localparam logic [CLK_W-1:0] Q_LIMIT = 28'd65536;
   localparam logic [VAL_W-1:0] VAL_MAX = 16'hFFFF;

   typedef struct packed {
      logic              bank;     // 0: channels 0/1, 1: channels 2/3
      logic [FREQ_W-1:0] freq_a;
      logic [BYTE_W-1:0] duty_a;
      logic [FREQ_W-1:0] freq_b;
      logic [BYTE_W-1:0] duty_b;
   } job_type;

endpackage

@@ src/cfpd_div.sv @@
// serial restoring divider, one quotient bit per cycle
module cfpd_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cfpd_pkg::CLK_W-1:0]   dividend,
   input  logic [cfpd_pkg::FREQ_W-1:0]  divisor,
   output logic                         done,
   output logic [cfpd_pkg::CLK_W-1:0]   quotient
);

   localparam int CW    = cfpd_pkg::CLK_W;
   localparam int DW    = cfpd_pkg::FREQ_W;
   localparam int CNT_W = $clog2(CW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW:0]      rem_ff, rem_in;
   logic [CW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [DW:0]      rem_sh;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff[DW-1:0], quo_ff[CW-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_in = {quo_ff[CW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/cfpd_front.sv @@
// frame intake: identifier match and a short job queue toward the back end
module cfpd_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cfpd_pkg::ID_W-1:0]    req_frame_id,
   input  logic [cfpd_pkg::BYTE_W-1:0]  req_byte0,
   input  logic [cfpd_pkg::BYTE_W-1:0]  req_byte1,
   input  logic [cfpd_pkg::BYTE_W-1:0]  req_byte2,
   input  logic [cfpd_pkg::BYTE_W-1:0]  req_byte3,
   input  logic [cfpd_pkg::BYTE_W-1:0]  req_byte4,
   input  logic [cfpd_pkg::BYTE_W-1:0]  req_byte5,
   input  logic [cfpd_pkg::ID_W-1:0]    first_id,
   input  logic [cfpd_pkg::ID_W-1:0]    second_id,
   output logic                         job_valid,
   output cfpd_pkg::job_type            job,
   input  logic                         job_pop
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cfpd_pkg::job_type slot_ff [QUEUE_DEPTH];
   cfpd_pkg::job_type slot_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  wr_idx;
   logic              match_first, match_second, push, pop;
   cfpd_pkg::job_type new_job;

   always_comb begin
      match_first  = req_frame_id == first_id;
      match_second = !match_first && (req_frame_id == second_id);
      req_ready    = count_ff != CNT_W'(QUEUE_DEPTH);
      // frames with other identifiers are taken and dropped
      push         = req_valid && req_ready && (match_first || match_second);
      pop          = job_pop && (count_ff != '0);
      new_job.bank   = match_second;
      new_job.freq_a = {req_byte1, req_byte0};
      new_job.duty_a = req_byte2;
      new_job.freq_b = {req_byte4, req_byte3};
      new_job.duty_b = req_byte5;
      wr_idx   = pop ? (count_ff - 1'b1) : count_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         if (pop && (i + 1 < QUEUE_DEPTH)) begin
            slot_in[i] = slot_ff[(i + 1) % QUEUE_DEPTH];
         end
         if (push && (wr_idx == CNT_W'(i))) begin
            slot_in[i] = new_job;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

   assign job_valid = count_ff != '0;
   assign job       = slot_ff[0];

endmodule

@@ src/cfpd_back.sv @@
// channel sequencer: divide, scale, clamp and hand out one result per channel
module cfpd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [cfpd_pkg::CLK_W-1:0]   clock_hz,
   input  logic                         job_valid,
   input  cfpd_pkg::job_type            job,
   output logic                         job_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cfpd_pkg::CHAN_W-1:0]  rsp_channel,
   output logic                         rsp_enable,
   output logic [cfpd_pkg::VAL_W-1:0]   rsp_period_top,
   output logic [cfpd_pkg::VAL_W-1:0]   rsp_compare,
   output logic                         rsp_saturated,
   output logic                         rsp_last
);

   localparam int CW = cfpd_pkg::CLK_W;
   localparam int VW = cfpd_pkg::VAL_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_MUL   = 5'b00100,
      S_SCALE = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      half_ff, half_in;
   logic      off_ff, off_in;
   logic [cfpd_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [cfpd_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic      big_ff, big_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cfpd_pkg::CHAN_W-1:0]  chan_ff, chan_in;
   logic                         en_ff, en_in;
   logic [VW-1:0]                top_ff, top_in;
   logic [VW-1:0]                cmp_ff, cmp_in;
   logic                         sat_ff, sat_in;
   logic                         last_ff, last_in;

   logic [cfpd_pkg::FREQ_W-1:0]  cur_freq;
   logic [cfpd_pkg::BYTE_W-1:0]  cur_duty;
   logic                         div_start, div_done;
   logic [CW-1:0]                quo;
   logic                         load, q_big;

   cfpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_hz),
      .divisor  (cur_freq),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      cur_freq  = half_ff ? job.freq_b : job.freq_a;
      cur_duty  = half_ff ? job.duty_b : job.duty_a;
      state_in  = state_ff;
      half_in   = half_ff;
      off_in    = off_ff;
      prod_in   = prod_ff;
      scaled_in = scaled_ff;
      big_in    = big_ff;
      div_start = 1'b0;
      job_pop   = 1'b0;
      q_big     = quo > cfpd_pkg::Q_LIMIT;
      // output register frees up when empty or being taken
      load      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

      chan_in = chan_ff;
      en_in   = en_ff;
      top_in  = top_ff;
      cmp_in  = cmp_ff;
      sat_in  = sat_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               if (cur_freq == '0 || cur_duty == '0) begin
                  off_in   = 1'b1;
                  state_in = S_FIN;
               end else begin
                  off_in    = 1'b0;
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = cur_duty * quo;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            big_in    = prod_ff >= cfpd_pkg::CMP_PROD_LIMIT;
            scaled_in = prod_ff[cfpd_pkg::SCALE_IN_W-1:0] * cfpd_pkg::RECIP_100;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               chan_in = {job.bank, half_ff};
               last_in = half_ff;
               if (off_ff) begin
                  en_in  = 1'b0;
                  top_in = '0;
                  cmp_in = '0;
                  sat_in = 1'b0;
               end else begin
                  en_in = 1'b1;
                  if (quo == '0) begin
                     top_in = '0;
                  end else if (q_big) begin
                     top_in = cfpd_pkg::VAL_MAX;
                  end else begin
                     top_in = VW'(quo - 1'b1);
                  end
                  cmp_in = big_ff ? cfpd_pkg::VAL_MAX
                                  : scaled_ff[cfpd_pkg::RECIP_SHIFT +: VW];
                  sat_in = q_big || big_ff;
               end
               if (half_ff) begin
                  job_pop = 1'b1;
                  half_in = 1'b0;
               end else begin
                  half_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff    <= off_in;
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
      big_ff    <= big_in;
      chan_ff   <= chan_in;
      en_ff     <= en_in;
      top_ff    <= top_in;
      cmp_ff    <= cmp_in;
      sat_ff    <= sat_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_channel    = chan_ff;
   assign rsp_enable     = en_ff;
   assign rsp_period_top = top_ff;
   assign rsp_compare    = cmp_ff;
   assign rsp_saturated  = sat_ff;
   assign rsp_last       = last_ff;

endmodule

@@ src/can_frame_to_pwm_period_duty.sv @@
// Frame to pwm settings: each accepted frame whose identifier matches first_id or
// second_id gives two result beats (channels 0/1 or 2/3, last set on the second);
// other frames are taken and give nothing. A front end takes one frame per cycle, while
// its queue has room, into a queue of QUEUE_DEPTH matched frames; the back end works one
// channel at a time through a single serial divider. Each channel goes through divider
// start, 28 quotient steps, done, multiply, scale, output load; a channel that is off skips
// straight to output load. Results wait in an output register while the front
// keeps accepting. Registers are written at once through csr_we; write them only while idle.
module can_frame_to_pwm_period_duty #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cfpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cfpd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cfpd_pkg::ID_W-1:0]       req_frame_id,
   input  logic [cfpd_pkg::BYTE_W-1:0]     req_byte0,
   input  logic [cfpd_pkg::BYTE_W-1:0]     req_byte1,
   input  logic [cfpd_pkg::BYTE_W-1:0]     req_byte2,
   input  logic [cfpd_pkg::BYTE_W-1:0]     req_byte3,
   input  logic [cfpd_pkg::BYTE_W-1:0]     req_byte4,
   input  logic [cfpd_pkg::BYTE_W-1:0]     req_byte5,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cfpd_pkg::CHAN_W-1:0]     rsp_channel,
   output logic                            rsp_enable,
   output logic [cfpd_pkg::VAL_W-1:0]      rsp_period_top,
   output logic [cfpd_pkg::VAL_W-1:0]      rsp_compare,
   output logic                            rsp_saturated,
   output logic                            rsp_last
);

   logic [cfpd_pkg::CLK_W-1:0] clock_hz_ff, clock_hz_in;
   logic [cfpd_pkg::ID_W-1:0]  first_id_ff, first_id_in;
   logic [cfpd_pkg::ID_W-1:0]  second_id_ff, second_id_in;

   logic              job_valid, job_pop;
   cfpd_pkg::job_type job;

   always_comb begin
      clock_hz_in  = clock_hz_ff;
      first_id_in  = first_id_ff;
      second_id_in = second_id_ff;
      if (csr_we) begin
         case (csr_index)
            cfpd_pkg::CSR_CLOCK_HZ:  clock_hz_in  = csr_wdata[cfpd_pkg::CLK_W-1:0];
            cfpd_pkg::CSR_FIRST_ID:  first_id_in  = csr_wdata[cfpd_pkg::ID_W-1:0];
            cfpd_pkg::CSR_SECOND_ID: second_id_in = csr_wdata[cfpd_pkg::ID_W-1:0];
            default: begin
               // unused index, write ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff  <= cfpd_pkg::CLOCK_HZ_RESET;
         first_id_ff  <= cfpd_pkg::FIRST_ID_RESET;
         second_id_ff <= cfpd_pkg::SECOND_ID_RESET;
      end else begin
         clock_hz_ff  <= clock_hz_in;
         first_id_ff  <= first_id_in;
         second_id_ff <= second_id_in;
      end
   end

   cfpd_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_frame_id (req_frame_id),
      .req_byte0    (req_byte0),
      .req_byte1    (req_byte1),
      .req_byte2    (req_byte2),
      .req_byte3    (req_byte3),
      .req_byte4    (req_byte4),
      .req_byte5    (req_byte5),
      .first_id     (first_id_ff),
      .second_id    (second_id_ff),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop)
   );

   cfpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .clock_hz       (clock_hz_ff),
      .job_valid      (job_valid),
      .job            (job),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_channel    (rsp_channel),
      .rsp_enable     (rsp_enable),
      .rsp_period_top (rsp_period_top),
      .rsp_compare    (rsp_compare),
      .rsp_saturated  (rsp_saturated),
      .rsp_last       (rsp_last)
   );

endmodule

@@ src/cfpd_checker.sv @@
// port-level checks for the frame to pwm settings block, bound to the top level
`include "can_frame_to_pwm_period_duty_macros.svh"

module cfpd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cfpd_pkg::CHAN_W-1:0]     rsp_channel,
   input logic                            rsp_enable,
   input logic [cfpd_pkg::VAL_W-1:0]      rsp_period_top,
   input logic [cfpd_pkg::VAL_W-1:0]      rsp_compare,
   input logic                            rsp_saturated,
   input logic                            rsp_last
);

   // whole result beat, for the hold check
   logic [cfpd_pkg::CHAN_W+2*cfpd_pkg::VAL_W+2:0] rsp_beat;
   logic                                          rsp_off_clear;

   assign rsp_beat = {rsp_channel, rsp_enable, rsp_period_top, rsp_compare,
                      rsp_saturated, rsp_last};
   assign rsp_off_clear = (rsp_period_top == '0) && (rsp_compare == '0) && !rsp_saturated;

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat))

   // nothing is offered right after reset
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

   // a channel that is off carries zero settings
   `ASSERT_IMPLIES(a_off_zero, clock, reset, rsp_valid && !rsp_enable, rsp_off_clear)

   // the second beat of a frame is always the odd channel
   `ASSERT_IMPLIES(a_last_odd, clock, reset, rsp_valid, rsp_last == rsp_channel[0])

endmodule

bind can_frame_to_pwm_period_duty cfpd_checker u_checker (.*);
